/* design/mbk_pkg.sv */
// morse beacon keyer package: register indexes, widths and the morse code tables
// no dependencies

package mbk_pkg;

  localparam int DEF_MAX_LETTERS = 8;
  localparam int SLOT_COUNT      = 8;
  localparam int CODE_W          = 5;
  localparam int TPD_W           = 16;
  localparam int MSG_W           = 40;
  localparam int LEN_W           = 4;
  localparam int TICKS_W         = 19;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 40;
  localparam int SYM_W           = 2;
  localparam int SYM_LEN_W       = 3;
  localparam logic [CODE_W-1:0] LAST_CODE = 5'd25;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TICKS_PER_DOT   = 2'd0,
    REG_MESSAGE_LETTERS = 2'd1,
    REG_MESSAGE_LENGTH  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic advance;
    logic blank;
  } stage_t;

  // symbols per letter, a to z
  localparam logic [SYM_LEN_W-1:0] CODE_LEN [0:25] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  // bit s set when symbol s is a dash
  localparam logic [3:0] CODE_BITS [0:25] = '{
    4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
    4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
  };

  // letter code at a position, slots past the register read as a, codes past z as z
  function automatic logic [CODE_W-1:0] letter_at(logic [MSG_W-1:0] msg,
                                                  logic [CODE_W-1:0] pos);
    logic [CODE_W-1:0] c;
    c = '0;
    if (pos < CODE_W'(SLOT_COUNT)) begin
      c = msg[pos[2:0]*CODE_W +: CODE_W];
    end
    if (c > LAST_CODE) begin
      c = LAST_CODE;
    end
    return c;
  endfunction

endpackage

/* design/mbk_in_if.sv */
// input channel of the keyer: valid/ready with advance and blank
// no dependencies

interface mbk_in_if;
  logic valid;
  logic ready;
  logic advance;
  logic blank;

  modport source(output valid, output advance, output blank, input ready);
  modport sink(input valid, input advance, input blank, output ready);
endinterface

/* design/mbk_out_if.sv */
// result channel of the keyer: valid/ready with light and word_wrapped
// no dependencies

interface mbk_out_if;
  logic valid;
  logic ready;
  logic light;
  logic word_wrapped;

  modport source(output valid, output light, output word_wrapped, input ready);
  modport sink(input valid, input light, input word_wrapped, output ready);
endinterface

/* design/morse_beacon_keyer.sv */
// morse beacon keyer top level: input register, keyer core and result channel
// depends on mbk_pkg, mbk_in_if, mbk_out_if, mbk_in_stage and mbk_core
//
// usage:
//   item carries one keying tick per transaction: advance lets the tick count,
//   blank forces light low for that tick without touching the timing.
//   result carries one transaction per input transaction: light is the keyed
//   output, word_wrapped marks the tick on which the word starts over.
//   registers are written through cfg_we / cfg_index / cfg_data while idle;
//   index 0 ticks_per_dot, 1 message_letters, 2 message_length. a write to any
//   of them restarts keying at the first mark of the word.
// path: an accepted item is held in the input register, then in the result
//   register, which drives result.
//   throughput: one transaction per cycle while result.ready is high.
// reset: synchronous, clears both stages and loads default registers
//   (one tick per dot, word "a", one letter); the first element is loaded on
//   the first tick after reset.
// stall: while result.ready is low the result is held and one more item can be
//   taken into the input register before item.ready drops.

module morse_beacon_keyer
  import mbk_pkg::*;
#(
  parameter int MAX_LETTERS = DEF_MAX_LETTERS
) (
  input  logic                   clk,
  input  logic                   rst,
  mbk_in_if.sink                 item,
  mbk_out_if.source              result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  stage_t stage;
  logic   drain;

  mbk_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .drain (drain),
    .stage (stage)
  );

  mbk_core #(
    .MAX_LETTERS (MAX_LETTERS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .stage     (stage),
    .drain     (drain),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

/* design/mbk_in_stage.sv */
// input register of the keyer, takes one transaction per cycle while it is empty or drain is high
// depends on mbk_pkg and mbk_in_if

module mbk_in_stage
  import mbk_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  mbk_in_if.sink       item,
  input  logic         drain,
  output stage_t       stage
);

  logic valid;
  logic advance;
  logic blank;

  assign item.ready = !valid || drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (item.ready) begin
      valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      advance <= item.advance;
      blank   <= item.blank;
    end
  end

  assign stage = '{valid: valid, advance: advance, blank: blank};

endmodule

/* design/mbk_core.sv */
// keyer state, configuration registers, element timing and result register
// depends on mbk_pkg and mbk_out_if

module mbk_core
  import mbk_pkg::*;
#(
  parameter int MAX_LETTERS = DEF_MAX_LETTERS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  stage_t                 stage,
  output logic                   drain,
  mbk_out_if.source              result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int LW  = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
  localparam int LCW = $clog2(MAX_LETTERS + 1);
  localparam int CW  = (LCW > LEN_W) ? LCW + 1 : LEN_W + 1;

  logic [TPD_W-1:0]   ticks_per_dot;
  logic [MSG_W-1:0]   message_letters;
  logic [LEN_W-1:0]   message_length;

  logic [LW-1:0]      letter_position;
  logic [SYM_W-1:0]   symbol_position;
  logic               in_gap;
  logic [TICKS_W-1:0] ticks_left;
  logic               restart_pending;

  logic [LW-1:0]      letter_position_next;
  logic [SYM_W-1:0]   symbol_position_next;
  logic               in_gap_next;
  logic [TICKS_W-1:0] ticks_left_next;
  logic               wrapped_next;

  logic               out_valid;
  logic               light;
  logic               word_wrapped;

  logic               fire;
  logic               cfg_hit;
  logic [TICKS_W-1:0] tpd1;
  logic [TICKS_W-1:0] tpd3;
  logic [TICKS_W-1:0] tpd7;
  logic [CW-1:0]      eff_len;
  logic               last_letter;
  logic               last_symbol;
  logic [LW-1:0]      lp_eff;
  logic [CODE_W-1:0]  code0;
  logic [CODE_W-1:0]  cur_code;
  logic [CODE_W-1:0]  nxt_code;
  logic [SYM_LEN_W-1:0] cur_len;
  logic [SYM_W-1:0]   sp_inc;
  logic [TICKS_W-1:0] first_ticks;
  logic [TICKS_W-1:0] tl_cur;
  logic [TICKS_W-1:0] next_ticks;
  logic               next_dash;

  assign drain   = !out_valid || result.ready;
  assign fire    = stage.valid && drain;
  assign cfg_hit = cfg_we && (cfg_index == REG_TICKS_PER_DOT ||
                              cfg_index == REG_MESSAGE_LETTERS ||
                              cfg_index == REG_MESSAGE_LENGTH);

  // unit lengths in ticks
  always_comb begin
    tpd1 = (ticks_per_dot == '0) ? TICKS_W'(1) : TICKS_W'(ticks_per_dot);
    tpd3 = (tpd1 << 1) + tpd1;
    tpd7 = (tpd1 << 3) - tpd1;
  end

  // position decode
  always_comb begin
    if (message_length == '0) begin
      eff_len = CW'(1);
    end else if (CW'(message_length) > CW'(MAX_LETTERS)) begin
      eff_len = CW'(MAX_LETTERS);
    end else begin
      eff_len = CW'(message_length);
    end
    last_letter = (CW'(letter_position) + CW'(1)) >= eff_len;
    lp_eff      = last_letter ? LW'(eff_len - CW'(1)) : letter_position;
    code0       = letter_at(message_letters, '0);
    cur_code    = letter_at(message_letters, CODE_W'(lp_eff));
    nxt_code    = last_letter ? code0
                  : letter_at(message_letters, CODE_W'(LW'(lp_eff + LW'(1))));
    cur_len     = CODE_LEN[cur_code];
    last_symbol = (SYM_LEN_W'(symbol_position) + SYM_LEN_W'(1)) >= cur_len;
    sp_inc      = symbol_position + SYM_W'(1);
    first_ticks = CODE_BITS[code0][0] ? tpd3 : tpd1;
    tl_cur      = restart_pending ? first_ticks : ticks_left;
  end

  // length of the element that follows the current one
  always_comb begin
    next_dash = 1'b0;
    if (!in_gap) begin
      if (!last_symbol) begin
        next_ticks = tpd1;
      end else if (!last_letter) begin
        next_ticks = tpd3;
      end else begin
        next_ticks = tpd7;
      end
    end else begin
      if (!last_symbol) begin
        next_dash = CODE_BITS[cur_code][sp_inc];
      end else begin
        next_dash = CODE_BITS[nxt_code][0];
      end
      next_ticks = next_dash ? tpd3 : tpd1;
    end
  end

  // state update for one tick
  always_comb begin
    letter_position_next = letter_position;
    symbol_position_next = symbol_position;
    in_gap_next          = in_gap;
    ticks_left_next      = tl_cur;
    wrapped_next         = 1'b0;
    if (stage.advance) begin
      if (tl_cur <= TICKS_W'(1)) begin
        ticks_left_next = next_ticks;
        in_gap_next     = !in_gap;
        if (in_gap) begin
          if (!last_symbol) begin
            symbol_position_next = sp_inc;
          end else begin
            symbol_position_next = '0;
            if (!last_letter) begin
              letter_position_next = LW'(letter_position + LW'(1));
            end else begin
              letter_position_next = '0;
              wrapped_next         = 1'b1;
            end
          end
        end
      end else begin
        ticks_left_next = tl_cur - TICKS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_dot   <= TPD_W'(1);
      message_letters <= '0;
      message_length  <= LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TICKS_PER_DOT:   ticks_per_dot   <= cfg_data[TPD_W-1:0];
        REG_MESSAGE_LETTERS: message_letters <= cfg_data[MSG_W-1:0];
        REG_MESSAGE_LENGTH:  message_length  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      letter_position <= '0;
      symbol_position <= '0;
      in_gap          <= 1'b0;
      ticks_left      <= '0;
      restart_pending <= 1'b1;
    end else if (fire) begin
      letter_position <= letter_position_next;
      symbol_position <= symbol_position_next;
      in_gap          <= in_gap_next;
      ticks_left      <= ticks_left_next;
      restart_pending <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain) begin
      out_valid <= stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      light        <= !in_gap_next && !stage.blank;
      word_wrapped <= wrapped_next;
    end
  end

  assign result.valid        = out_valid;
  assign result.light        = light;
  assign result.word_wrapped = word_wrapped;

  a_restart_pending: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> restart_pending)
    else $error("keyer not restarted after register write");

  a_wrap_to_start: assert property (@(posedge clk) disable iff (rst)
    fire && wrapped_next && !cfg_hit |=>
      letter_position == '0 && symbol_position == '0 && !in_gap)
    else $error("wrap did not return to first mark");

  a_ticks_loaded: assert property (@(posedge clk) disable iff (rst)
    !restart_pending |-> ticks_left != '0)
    else $error("element timer empty after load");

  a_symbol_in_letter: assert property (@(posedge clk) disable iff (rst)
    (SYM_LEN_W'(symbol_position) + SYM_LEN_W'(1)) <= cur_len)
    else $error("symbol position past end of letter");

  a_fire_consumes: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("accepted tick produced no result");

endmodule
